@@ design/gpwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear pulse width decoder package
// Shared widths, register indexes, type codes and state/config structs.
// ----------------------------------------------------------------------------
package gpwd_pkg;

  localparam int COUNT_BITS   = 14;
  localparam int REG_BITS     = 14;
  localparam int TYPE_BITS    = 5;
  localparam int GEAR_BITS    = 7;
  localparam int CFG_IDX_BITS = 3;

  // tick count plus a small offset, never wraps
  localparam int SUM_BITS = COUNT_BITS + 1;
  localparam int CMP_BITS = (SUM_BITS > REG_BITS) ? SUM_BITS : REG_BITS;

  // floor(x / 100) as (x * RECIP_MUL) >> RECIP_SHIFT, exact for x < 91000
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_BITS  = 17;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(83887);
  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;
  localparam int Q_BITS    = PROD_BITS - RECIP_SHIFT;
  localparam int GQ_BITS   = (Q_BITS > GEAR_BITS) ? Q_BITS : GEAR_BITS;

  localparam logic [SUM_BITS-1:0] HIGH_OFFSET = SUM_BITS'(10);
  localparam logic [SUM_BITS-1:0] LOW_OFFSET  = SUM_BITS'(20);
  localparam logic [GQ_BITS-1:0]  GEAR_MAX    = GQ_BITS'(127);

  localparam logic [TYPE_BITS-1:0] TYPE_NONE = TYPE_BITS'(0);
  localparam logic [TYPE_BITS-1:0] TYPE_5    = TYPE_BITS'(5);
  localparam logic [TYPE_BITS-1:0] TYPE_10   = TYPE_BITS'(10);
  localparam logic [TYPE_BITS-1:0] TYPE_20   = TYPE_BITS'(20);

  localparam logic [REG_BITS-1:0] TIMEOUT_RST   = REG_BITS'(10000);
  localparam logic [REG_BITS-1:0] INVALID_RST   = REG_BITS'(80);
  localparam logic [REG_BITS-1:0] TYPE5_RST     = REG_BITS'(120);
  localparam logic [REG_BITS-1:0] TYPE10_RST    = REG_BITS'(260);
  localparam logic [REG_BITS-1:0] TYPE20_RST    = REG_BITS'(440);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TIMEOUT = 3'd0,
    REG_INVALID = 3'd1,
    REG_TYPE5   = 3'd2,
    REG_TYPE10  = 3'd3,
    REG_TYPE20  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_BITS-1:0] timeout_ticks;
    logic [REG_BITS-1:0] invalid_below;
    logic [REG_BITS-1:0] type5_below;
    logic [REG_BITS-1:0] type10_below;
    logic [REG_BITS-1:0] type20_below;
  } dec_cfg_t;

  typedef struct packed {
    logic                  last_level;
    logic                  await_rising;
    logic [COUNT_BITS-1:0] tick_count;
    logic [TYPE_BITS-1:0]  held_type;
    logic [GEAR_BITS-1:0]  held_gear;
    logic                  changed_flag;
  } dec_state_t;

endpackage

@@ design/gpwd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear pulse width decoder step
// Next decoder state for one line sample: edge detection, high time
// classification, gear computation and tick counter with timeout.
// ----------------------------------------------------------------------------
module gpwd_step (
  input  gpwd_pkg::dec_cfg_t   cfg,
  input  gpwd_pkg::dec_state_t cur,
  input  logic                 line_level,
  input  logic                 clear_changed,
  output gpwd_pkg::dec_state_t nxt
);
  import gpwd_pkg::*;

  logic                  fall_armed;
  logic                  rise_armed;
  logic [SUM_BITS-1:0]   high_time;
  logic [SUM_BITS-1:0]   low_time;
  logic [CMP_BITS-1:0]   high_cmp;
  logic [TYPE_BITS-1:0]  new_type;
  logic [PROD_BITS-1:0]  prod;
  logic [GQ_BITS-1:0]    ms_div5;
  logic [GQ_BITS-1:0]    gear_raw;
  logic [GEAR_BITS-1:0]  gear_sat;
  logic [COUNT_BITS-1:0] tick_inc;
  logic                  timeout_hit;

  assign fall_armed = cur.last_level & ~line_level & ~cur.await_rising;
  assign rise_armed = ~cur.last_level & line_level & cur.await_rising;

  assign high_time = SUM_BITS'(cur.tick_count) + HIGH_OFFSET;
  assign low_time  = SUM_BITS'(cur.tick_count) + LOW_OFFSET;
  assign high_cmp  = CMP_BITS'(high_time);

  always_comb begin
    if (high_cmp < CMP_BITS'(cfg.invalid_below)) begin
      new_type = TYPE_NONE;
    end else if (high_cmp < CMP_BITS'(cfg.type5_below)) begin
      new_type = TYPE_5;
    end else if (high_cmp < CMP_BITS'(cfg.type10_below)) begin
      new_type = TYPE_10;
    end else if (high_cmp < CMP_BITS'(cfg.type20_below)) begin
      new_type = TYPE_20;
    end else begin
      new_type = TYPE_NONE;
    end
  end

  // (low_time / 20) / type == low_time / (20 * type)
  assign prod    = PROD_BITS'(low_time) * PROD_BITS'(RECIP_MUL);
  assign ms_div5 = GQ_BITS'(prod[PROD_BITS-1:RECIP_SHIFT]);

  always_comb begin
    case (cur.held_type)
      TYPE_5:  gear_raw = ms_div5;
      TYPE_10: gear_raw = ms_div5 >> 1;
      TYPE_20: gear_raw = ms_div5 >> 2;
      default: gear_raw = '0;
    endcase
    if (gear_raw > GEAR_MAX) begin
      gear_sat = GEAR_BITS'(GEAR_MAX);
    end else begin
      gear_sat = GEAR_BITS'(gear_raw);
    end
  end

  assign tick_inc    = cur.tick_count + COUNT_BITS'(1);
  assign timeout_hit = CMP_BITS'(tick_inc) == CMP_BITS'(cfg.timeout_ticks);

  always_comb begin
    nxt            = cur;
    nxt.last_level = line_level;
    if (clear_changed) begin
      nxt.changed_flag = 1'b0;
    end
    if (fall_armed) begin
      nxt.held_type    = new_type;
      nxt.tick_count   = '0;
      nxt.await_rising = 1'b1;
      if (new_type == TYPE_NONE) begin
        nxt.held_gear = '0;
      end
    end else if (rise_armed) begin
      nxt.tick_count   = '0;
      nxt.await_rising = 1'b0;
      if (cur.held_type != TYPE_NONE && gear_sat != cur.held_gear) begin
        nxt.held_gear    = gear_sat;
        nxt.changed_flag = 1'b1;
      end
    end else if (timeout_hit) begin
      nxt.tick_count   = '0;
      nxt.await_rising = 1'b1;
    end else begin
      nxt.tick_count = tick_inc;
    end
  end

endmodule

@@ design/gear_pulse_width_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear pulse width decoder
// Decodes transmission type and gear from a sampled two-pulse line.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  in_line_level, in_clear_changed
//   out      output     out_valid/out_stall out_trans_type, out_gear_code,
//                                          out_gear_changed
//   cfg      input      cfg_we             cfg_idx, cfg_wdata
//
// One transaction per clock; the result appears the cycle after acceptance.
// The decoder state doubles as the output register, so a result stalled on
// the output holds the input off; a result taken frees the input that cycle.
// The state update is one pass through the classifier and a constant
// reciprocal multiply. Synchronous reset restores register defaults.
// ----------------------------------------------------------------------------
module gear_pulse_width_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_line_level,
  input  logic                                in_clear_changed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gpwd_pkg::TYPE_BITS-1:0]      out_trans_type,
  output logic [gpwd_pkg::GEAR_BITS-1:0]      out_gear_code,
  output logic                                out_gear_changed,
  input  logic                                cfg_we,
  input  logic [gpwd_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [gpwd_pkg::REG_BITS-1:0]       cfg_wdata
);
  import gpwd_pkg::*;

  dec_cfg_t   cfg_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  logic       out_valid_r;
  logic       in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  gpwd_step u_step (
    .cfg           (cfg_r),
    .cur           (state_r),
    .line_level    (in_line_level),
    .clear_changed (in_clear_changed),
    .nxt           (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.invalid_below <= INVALID_RST;
      cfg_r.type5_below   <= TYPE5_RST;
      cfg_r.type10_below  <= TYPE10_RST;
      cfg_r.type20_below  <= TYPE20_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        REG_INVALID: cfg_r.invalid_below <= cfg_wdata;
        REG_TYPE5:   cfg_r.type5_below   <= cfg_wdata;
        REG_TYPE10:  cfg_r.type10_below  <= cfg_wdata;
        REG_TYPE20:  cfg_r.type20_below  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_level   <= 1'b1;
      state_r.await_rising <= 1'b0;
      state_r.tick_count   <= '0;
      state_r.held_type    <= TYPE_NONE;
      state_r.held_gear    <= '0;
      state_r.changed_flag <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trans_type   = state_r.held_type;
  assign out_gear_code    = state_r.held_gear;
  assign out_gear_changed = state_r.changed_flag;

endmodule
